>>> design/cdfbs_pkg.sv
// shared types and constants for the cdf bucket search block
package cdfbs_pkg;

   // field widths
   localparam int VALUE_W  = 32;
   localparam int CAT_W    = 8;
   localparam int COUNT_W  = 9;
   localparam int ENTRY_W  = VALUE_W + 1;

   // largest table the 8-bit category index can reach
   localparam int INDEX_LIMIT = 256;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_CATEGORY_COUNT = 1'b0;
   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

   // search sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

>>> design/cdfbs_req_if.sv
// request channel: table writes and queries
interface cdfbs_req_if
   import cdfbs_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [CAT_W-1:0]   entry_index;
   logic [VALUE_W-1:0] cumulative_value;
   logic [VALUE_W-1:0] category_probability;
   logic [VALUE_W-1:0] sample_value;

   modport source (
      output valid, operation, entry_index, cumulative_value,
             category_probability, sample_value,
      input  ready
   );
   modport sink (
      input  valid, operation, entry_index, cumulative_value,
             category_probability, sample_value,
      output ready
   );
endinterface

>>> design/cdfbs_rsp_if.sv
// response channel: chosen category
interface cdfbs_rsp_if
   import cdfbs_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CAT_W-1:0] chosen_category;

   modport source (
      output valid, chosen_category,
      input  ready
   );
   modport sink (
      input  valid, chosen_category,
      output ready
   );
endinterface

>>> design/cdfbs_ram.sv
// generic single-port-write, single-port-read ram with registered read
module cdfbs_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/cdfbs_csr.sv
// apb register file: category count and its clamped working value
module cdfbs_csr
   import cdfbs_pkg::*;
#(
   parameter int MAX_CATEGORIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [$clog2((MAX_CATEGORIES < INDEX_LIMIT) ? MAX_CATEGORIES : INDEX_LIMIT):0]
                                 eff_count
);

   localparam int DEPTH = (MAX_CATEGORIES < INDEX_LIMIT) ? MAX_CATEGORIES : INDEX_LIMIT;
   localparam int CW    = $clog2(DEPTH) + 1;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               wr_hit;
   logic               reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_hit     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (reg_sel == REG_CATEGORY_COUNT);

   // count register
   always_comb begin
      count_in = count_ff;
      if (wr_hit) begin
         count_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   // readback
   always_comb begin
      csr_prdata = '0;
      if (reg_sel == REG_CATEGORY_COUNT) begin
         csr_prdata = CSR_DATA_W'(count_ff);
      end
   end

   // clamp to the table in use: at least one, at most the depth
   always_comb begin
      if (count_ff == '0) begin
         eff_count = CW'(1);
      end else if (count_ff > COUNT_W'(DEPTH)) begin
         eff_count = CW'(DEPTH);
      end else begin
         eff_count = CW'(count_ff);
      end
   end

endmodule

>>> design/cdfbs_search.sv
// search sequencer: table writes, binary search, backward walk, result register
module cdfbs_search
   import cdfbs_pkg::*;
#(
   parameter int MAX_CATEGORIES = 256
) (
   input  logic clock,
   input  logic reset,
   cdfbs_req_if.sink   req_if,
   cdfbs_rsp_if.source rsp_if,
   input  logic [$clog2((MAX_CATEGORIES < INDEX_LIMIT) ? MAX_CATEGORIES : INDEX_LIMIT):0]
                 eff_count,
   output logic                 ram_wr_en,
   output logic [$clog2((MAX_CATEGORIES < INDEX_LIMIT) ? MAX_CATEGORIES : INDEX_LIMIT)-1:0]
                                ram_wr_addr,
   output logic [ENTRY_W-1:0]   ram_wr_data,
   output logic [$clog2((MAX_CATEGORIES < INDEX_LIMIT) ? MAX_CATEGORIES : INDEX_LIMIT)-1:0]
                                ram_rd_addr,
   input  logic [ENTRY_W-1:0]   ram_rd_data
);

   localparam int DEPTH = (MAX_CATEGORIES < INDEX_LIMIT) ? MAX_CATEGORIES : INDEX_LIMIT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = AW + 1;

   state_type          state_ff, state_in;
   logic [CW-1:0]      lo_ff, lo_in;
   logic [CW-1:0]      hi_ff, hi_in;
   logic [AW-1:0]      mid_ff, mid_in;
   logic [VALUE_W-1:0] sample_ff, sample_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CAT_W-1:0]   rsp_cat_ff, rsp_cat_in;

   logic               accept;
   logic               is_query;
   logic               less;
   logic [CW-1:0]      probe_lo;
   logic [CW-1:0]      probe_hi;
   logic [CW:0]        probe_sum;
   logic [AW-1:0]      probe_mid;
   logic               probe_more;
   logic [CW-1:0]      walk_start;
   logic               mark;
   logic [CW-1:0]      walk_prev;
   logic               out_free;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign is_query     = (req_if.operation == OP_QUERY);
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // table write straight from the request word
   assign ram_wr_en   = accept && (req_if.operation == OP_WRITE)
                        && (32'(req_if.entry_index) < 32'(MAX_CATEGORIES));
   assign ram_wr_addr = AW'(req_if.entry_index);
   assign ram_wr_data = {(req_if.category_probability != '0), req_if.cumulative_value};

   // shared compare step: narrow the interval, pick the next probe and the walk start and step
   always_comb begin
      less       = ram_rd_data[VALUE_W-1:0] < sample_ff;
      probe_lo   = less ? (CW'(mid_ff) + CW'(1)) : lo_ff;
      probe_hi   = less ? hi_ff : CW'(mid_ff);
      probe_sum  = {1'b0, probe_lo} + {1'b0, probe_hi};
      probe_mid  = probe_sum[AW:1];
      probe_more = probe_hi > probe_lo;
      walk_start = (probe_lo >= eff_count) ? (eff_count - CW'(1)) : probe_lo;
      mark       = ram_rd_data[VALUE_W];
      walk_prev  = lo_ff - CW'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (!probe_more) begin
               state_in = (walk_start != '0) ? ST_WALK : ST_DONE;
            end
         end
         ST_WALK: begin
            if (mark || (walk_prev == '0)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and ram read address
   always_comb begin
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      sample_in    = sample_ff;
      rsp_cat_in   = rsp_cat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      ram_rd_addr  = mid_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) begin
               lo_in       = '0;
               hi_in       = eff_count;
               sample_in   = req_if.sample_value;
               mid_in      = AW'(eff_count >> 1);
               ram_rd_addr = AW'(eff_count >> 1);
            end
         end
         ST_PROBE: begin
            if (probe_more) begin
               lo_in       = probe_lo;
               hi_in       = probe_hi;
               mid_in      = probe_mid;
               ram_rd_addr = probe_mid;
            end else begin
               lo_in       = walk_start;
               ram_rd_addr = walk_start[AW-1:0];
            end
         end
         ST_WALK: begin
            if (!mark) begin
               lo_in       = walk_prev;
               ram_rd_addr = walk_prev[AW-1:0];
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cat_in   = CAT_W'(lo_ff);
            end
         end
         default: begin
            lo_in = lo_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      sample_ff  <= sample_in;
      rsp_cat_ff <= rsp_cat_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.chosen_category = rsp_cat_ff;

endmodule

>>> design/cdf_bucket_search_core.sv
// top level of the inverse-cdf bucket search block
//
//   channel   direction  handshake            word
//   req_if    in         valid/ready          operation, entry index, values, sample
//   rsp_if    out        valid/ready          chosen category
//   csr_*     in         apb write/read       category count at byte address 0
//
// a table write is taken straight from the request word and leaves the block ready again at once.
// a query is accepted in the idle state, probes the table in the probe state once per
// step of the binary search, steps back in the walk state over each category examined
// above category 0 and ends in the done state; one ram read port, one probe per cycle,
// sets the pace of the search.
// reset is synchronous; the table is not cleared and holds garbage until written.
// a result waiting on rsp_if does not block new requests; a query that finishes
// while the result register is still full waits there.
module cdf_bucket_search_core
   import cdfbs_pkg::*;
#(
   parameter int MAX_CATEGORIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   cdfbs_req_if.sink             req_if,
   cdfbs_rsp_if.source           rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int DEPTH = (MAX_CATEGORIES < INDEX_LIMIT) ? MAX_CATEGORIES : INDEX_LIMIT;
   localparam int AW    = $clog2(DEPTH);

   logic [AW:0]        eff_count;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [AW-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;

   // configuration registers
   cdfbs_csr #(
      .MAX_CATEGORIES (MAX_CATEGORIES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .eff_count   (eff_count)
   );

   // cumulative value and nonzero mark per category
   cdfbs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // search sequencer
   cdfbs_search #(
      .MAX_CATEGORIES (MAX_CATEGORIES)
   ) u_search (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .eff_count   (eff_count),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

endmodule
